// ----- rtl/rc4_pkg.sv -----
// Shared types and constants for the RC4 stream cipher block.
`default_nettype none
package rc4_pkg;

    localparam int PERM_SIZE = 256;
    localparam int PERM_AW   = 8;
    localparam int BYTE_W    = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_I,
        ST_D_J,
        ST_D_SW1,
        ST_D_SW2,
        ST_D_OUT,
        ST_K_INIT,
        ST_K_RD,
        ST_K_M,
        ST_K_SW1,
        ST_K_SW2
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_D_I,
        OP_D_J,
        OP_D_SW1,
        OP_D_SW2,
        OP_D_OUT,
        OP_K_INIT,
        OP_K_RD,
        OP_K_M,
        OP_K_SW1,
        OP_K_SW2
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
        logic k_last;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- rtl/rc4_ctrl.sv -----
// Controller state machine sequencing key schedule rounds and keystream steps.
`default_nettype none
module rc4_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_in_type,
    input  wire logic             i_in_last,
    input  wire logic             i_out_ready,
    output rc4_pkg::t_dp_cmd      o_cmd,
    input  wire rc4_pkg::t_dp_sts i_sts
);
    import rc4_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    if (i_in_type) begin
                        n_state = ST_D_I;
                    end else if (i_in_last) begin
                        n_state = ST_K_INIT;
                    end
                end
            end
            ST_D_I: begin
                o_cmd.op = OP_D_I;
                n_state  = ST_D_J;
            end
            ST_D_J: begin
                o_cmd.op = OP_D_J;
                n_state  = ST_D_SW1;
            end
            ST_D_SW1: begin
                o_cmd.op = OP_D_SW1;
                n_state  = ST_D_SW2;
            end
            ST_D_SW2: begin
                o_cmd.op = OP_D_SW2;
                n_state  = ST_D_OUT;
            end
            ST_D_OUT: begin
                // hold until the output register is free
                if (!i_sts.out_busy || i_out_ready) begin
                    o_cmd.op = OP_D_OUT;
                    n_state  = ST_IDLE;
                end
            end
            ST_K_INIT: begin
                o_cmd.op = OP_K_INIT;
                n_state  = ST_K_RD;
            end
            ST_K_RD: begin
                o_cmd.op = OP_K_RD;
                n_state  = ST_K_M;
            end
            ST_K_M: begin
                o_cmd.op = OP_K_M;
                n_state  = ST_K_SW1;
            end
            ST_K_SW1: begin
                o_cmd.op = OP_K_SW1;
                n_state  = ST_K_SW2;
            end
            ST_K_SW2: begin
                o_cmd.op = OP_K_SW2;
                n_state  = i_sts.k_last ? ST_IDLE : ST_K_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/rc4_dp.sv -----
// Datapath: permutation memory, key store, indices and output register.
`default_nettype none
module rc4_dp #(
    parameter int MAX_KEY_LEN = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rc4_pkg::t_dp_cmd              i_cmd,
    output rc4_pkg::t_dp_sts                   o_sts,
    input  wire logic                          i_in_type,
    input  wire logic [rc4_pkg::BYTE_W-1:0]    i_in_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [2*rc4_pkg::BYTE_W-1:0]       o_out_data
);
    import rc4_pkg::*;

    localparam int KW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int CW = $clog2(MAX_KEY_LEN + 1);

    // permutation memory; an entry whose valid bit is clear reads as its address
    logic [BYTE_W-1:0]    r_perm [PERM_SIZE];
    logic [PERM_SIZE-1:0] r_pvld;
    logic [BYTE_W-1:0]    r_rd_data;
    logic [PERM_AW-1:0]   r_rd_addr;
    logic                 r_rd_vld;

    logic [BYTE_W-1:0]    r_key [MAX_KEY_LEN];
    logic [BYTE_W-1:0]    r_kb;

    logic [PERM_AW-1:0] r_i, n_i, r_j, n_j, r_t, n_t;
    logic [BYTE_W-1:0]  r_si, n_si, r_sj, n_sj, r_sk, n_sk, r_byte, n_byte;
    logic [PERM_AW-1:0] r_k, n_k, r_m, n_m;
    logic [KW-1:0]      r_kidx, n_kidx;
    logic [CW-1:0]      r_cnt, n_cnt, r_klen, n_klen;
    logic               r_out_valid, n_out_valid;
    logic [2*BYTE_W-1:0] r_out_data, n_out_data;

    logic               w_pwe, w_pre, w_kwe, w_clr;
    logic [PERM_AW-1:0] w_pwa, w_pra;
    logic [BYTE_W-1:0]  w_pwd, w_pval, w_ks, w_sum;
    logic [CW-1:0]      w_kinc;

    assign w_pval = r_rd_vld ? r_rd_data : r_rd_addr;
    assign w_kinc = CW'(r_kidx) + CW'(1);

    always_comb begin
        n_i = r_i;  n_j = r_j;  n_t = r_t;
        n_si = r_si; n_sj = r_sj; n_sk = r_sk; n_byte = r_byte;
        n_k = r_k;  n_m = r_m;  n_kidx = r_kidx;
        n_cnt = r_cnt; n_klen = r_klen;
        n_out_data = r_out_data;
        n_out_valid = r_out_valid && !i_out_ready;
        w_pwe = 1'b0; w_pwa = r_i; w_pwd = r_si;
        w_pre = 1'b0; w_pra = r_i;
        w_kwe = 1'b0; w_clr = 1'b0;
        w_ks  = w_pval;
        w_sum = r_m + w_pval + r_kb;
        case (i_cmd.op)
            OP_ACCEPT: begin
                n_byte = i_in_byte;
                // drop key bytes once the store is full
                if (!i_in_type && (r_cnt < CW'(MAX_KEY_LEN))) begin
                    w_kwe = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            OP_D_I: begin
                n_i   = r_i + PERM_AW'(1);
                w_pre = 1'b1;
                w_pra = n_i;
            end
            OP_D_J: begin
                n_si  = w_pval;
                n_j   = r_j + w_pval;
                w_pre = 1'b1;
                w_pra = n_j;
            end
            OP_D_SW1: begin
                n_sj  = w_pval;
                w_pwe = 1'b1;
                w_pwa = r_i;
                w_pwd = w_pval;
                n_t   = r_si + w_pval;
                w_pre = 1'b1;
                w_pra = n_t;
            end
            OP_D_SW2: begin
                w_pwe = 1'b1;
                w_pwa = r_j;
                w_pwd = r_si;
            end
            OP_D_OUT: begin
                // the read of S[t] saw the table before the swap: forward
                if (r_t == r_j) begin
                    w_ks = r_si;
                end else if (r_t == r_i) begin
                    w_ks = r_sj;
                end
                n_out_data  = {w_ks, r_byte ^ w_ks};
                n_out_valid = 1'b1;
            end
            OP_K_INIT: begin
                w_clr  = 1'b1;
                n_m    = '0;
                n_k    = '0;
                n_kidx = '0;
                n_i    = '0;
                n_j    = '0;
                n_klen = (r_cnt == '0) ? CW'(1) : r_cnt;
                n_cnt  = '0;
            end
            OP_K_RD: begin
                w_pre = 1'b1;
                w_pra = r_k;
            end
            OP_K_M: begin
                n_sk  = w_pval;
                n_m   = w_sum;
                w_pre = 1'b1;
                w_pra = w_sum;
            end
            OP_K_SW1: begin
                w_pwe = 1'b1;
                w_pwa = r_k;
                w_pwd = w_pval;
            end
            OP_K_SW2: begin
                w_pwe  = 1'b1;
                w_pwa  = r_m;
                w_pwd  = r_sk;
                n_k    = r_k + PERM_AW'(1);
                n_kidx = (w_kinc == r_klen) ? '0 : w_kinc[KW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            r_perm[w_pwa] <= w_pwd;
        end
        if (w_pre) begin
            r_rd_data <= r_perm[w_pra];
            r_rd_addr <= w_pra;
            r_rd_vld  <= r_pvld[w_pra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            r_pvld <= '0;
        end else if (w_pwe) begin
            r_pvld[w_pwa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_kwe) begin
            r_key[r_cnt[KW-1:0]] <= i_in_byte;
        end
        if (i_cmd.op == OP_K_RD) begin
            r_kb <= r_key[r_kidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_j         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_i         <= n_i;
            r_j         <= n_j;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t        <= n_t;
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_sk       <= n_sk;
        r_byte     <= n_byte;
        r_k        <= n_k;
        r_m        <= n_m;
        r_kidx     <= n_kidx;
        r_klen     <= n_klen;
        r_out_data <= n_out_data;
    end

    assign o_sts.out_busy = r_out_valid;
    assign o_sts.k_last   = (r_k == '1);
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.op == OP_D_OUT))
        else $error("result raised without a keystream step");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_KEY_LEN))
        else $error("key count beyond key store depth");

    a_klen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_K_INIT |=> r_klen != '0)
        else $error("key schedule started with zero length");

    a_kidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_K_RD |-> CW'(r_kidx) < r_klen)
        else $error("key index outside stored key");

endmodule
`default_nettype wire

// ----- rtl/rc4_stream_cipher.sv -----
// Top level of the RC4 stream cipher: stream ports, controller and datapath.
// Key beat: taken in the idle state; the beat marked tlast then runs the key schedule,
//   an init step and 256 rounds of read, mix and swap writes; no beat is taken meanwhile.
// Data beat: i, j, swap and output steps, then the result is registered; no new beat
//   is taken before the output step, set by the single read and write ports of the memory.
// Reset (i_rst_n low, synchronous) clears indices, key count, output valid and the
//   permutation valid bits, so the table reads as identity at once: no clearing pass.
`default_nettype none
module rc4_stream_cipher #(
    parameter int MAX_KEY_LEN = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic        s_axis_tuser,   // [0] req_type: 0 key byte, 1 data byte
    input  wire logic        s_axis_tlast,   // key_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [7:0] out_byte, [15:8] keystream_byte
);
    import rc4_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // controller: accepts a beat only when idle, then steps the datapath
    rc4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_type   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // datapath: permutation table, key store and the output register that
    // holds a finished beat while the sink stalls
    rc4_dp #(
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_type   (s_axis_tuser),
        .i_in_byte   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire
